// File: design/dsc_pkg.sv
// Shared types, codes and constants for the diagnostic session controller.
`default_nettype none

package dsc_pkg;

    // Field widths.
    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int TIME_W    = 16;
    localparam int S3_W      = 31;
    localparam int SEL_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 31;

    // Request checks.
    localparam logic [BYTE_W-1:0] VALID_REQ_LEN = 8'd2;
    localparam logic [BYTE_W-1:0] SID_POSITIVE_BIT = 8'h40;
    localparam logic [BYTE_W-1:0] SID_NEGATIVE = 8'h7F;

    // Subfunction values that select a session (suppress bit removed).
    localparam logic [SEL_W-1:0] SUB_DEFAULT     = 7'h01;
    localparam logic [SEL_W-1:0] SUB_PROGRAMMING = 7'h02;
    localparam logic [SEL_W-1:0] SUB_EXTENDED    = 7'h03;

    // Operation codes of an incoming item.
    typedef enum logic [OP_W-1:0] {
        OP_REQUEST = 2'd0,
        OP_RESTART = 2'd1,
        OP_TICK    = 2'd2,
        OP_UNUSED  = 2'd3
    } opcode_t;

    // Session codes.
    typedef enum logic [1:0] {
        SESS_DEFAULT     = 2'd1,
        SESS_PROGRAMMING = 2'd2,
        SESS_EXTENDED    = 2'd3
    } session_t;

    // Response kinds.
    typedef enum logic [1:0] {
        RESP_NONE     = 2'd0,
        RESP_POSITIVE = 2'd1,
        RESP_NEGATIVE = 2'd2
    } resp_kind_t;

    // Negative response codes.
    localparam logic [BYTE_W-1:0] NRC_NONE                = 8'h00;
    localparam logic [BYTE_W-1:0] NRC_NOT_SUPPORTED       = 8'h11;
    localparam logic [BYTE_W-1:0] NRC_SUBFUNC_UNSUPPORTED = 8'h12;
    localparam logic [BYTE_W-1:0] NRC_BAD_LENGTH          = 8'h13;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SERVICE_ENABLED    = 3'd0,
        CFG_FUNCTIONAL_ALLOWED = 3'd1,
        CFG_P2_TIME            = 3'd2,
        CFG_P2MAX_TIME         = 3'd3,
        CFG_S3_EXTENDED        = 3'd4,
        CFG_S3_PROGRAMMING     = 3'd5
    } cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [TIME_W-1:0] P2_TIME_RESET    = 16'd50;
    localparam logic [TIME_W-1:0] P2MAX_TIME_RESET = 16'd500;
    localparam logic [S3_W-1:0]   S3_RESET         = 31'd5000;

    // Configuration as seen by the processing logic.
    typedef struct packed {
        logic              service_enabled;
        logic              functional_allowed;
        logic [TIME_W-1:0] p2_time;
        logic [TIME_W-1:0] p2max_time;
        logic [S3_W-1:0]   s3_extended_ms;
        logic [S3_W-1:0]   s3_programming_ms;
    } cfg_t;

    // One incoming item.
    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [BYTE_W-1:0] req_length;
        logic [BYTE_W-1:0] service_id;
        logic [BYTE_W-1:0] subfunction_byte;
        logic              is_functional;
        logic [TIME_W-1:0] elapsed_ms;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [1:0]        resp_kind;
        logic [BYTE_W-1:0] resp_sid;
        logic [BYTE_W-1:0] resp_param;
        logic [BYTE_W-1:0] nrc_code;
        logic [TIME_W-1:0] resp_p2;
        logic [TIME_W-1:0] resp_p2max;
        logic [1:0]        active_session;
        logic              timed_out;
    } result_t;

endpackage

`default_nettype wire

// File: design/diagnostic_session_controller.sv
// Top level of the diagnostic session controller: request and result registers.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | opcode, req_length, service_id,
//           |                      | subfunction_byte, is_functional, elapsed_ms
//  out      | out_valid / out_ready| resp_kind, resp_sid, resp_param, nrc_code,
//           |                      | resp_p2, resp_p2max, active_session, timed_out
//  cfg      | cfg_we               | cfg_index, cfg_wdata
//
// One request is accepted per cycle while in_ready is high; its single result moves
// from the request register into the result register and is held there until
// out_ready takes it. The session and timer registers update as the result loads.
// Reset returns to the default session with the timer stopped and the registers
// at their reset values. A stalled output holds its result while the request
// register keeps one more request; in_ready drops only when both are full.
`default_nettype none

module diagnostic_session_controller (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [dsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dsc_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [dsc_pkg::OP_W-1:0]       opcode,
    input  wire logic [dsc_pkg::BYTE_W-1:0]     req_length,
    input  wire logic [dsc_pkg::BYTE_W-1:0]     service_id,
    input  wire logic [dsc_pkg::BYTE_W-1:0]     subfunction_byte,
    input  wire logic                           is_functional,
    input  wire logic [dsc_pkg::TIME_W-1:0]     elapsed_ms,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [1:0]                          resp_kind,
    output logic [dsc_pkg::BYTE_W-1:0]          resp_sid,
    output logic [dsc_pkg::BYTE_W-1:0]          resp_param,
    output logic [dsc_pkg::BYTE_W-1:0]          nrc_code,
    output logic [dsc_pkg::TIME_W-1:0]          resp_p2,
    output logic [dsc_pkg::TIME_W-1:0]          resp_p2max,
    output logic [1:0]                          active_session,
    output logic                                timed_out
);
    import dsc_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result;
    result_t result_reg;
    logic    result_valid_reg;
    logic    advance;
    logic    in_accept;

    dsc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The held request moves on whenever the result register is free or being read.
    assign advance   = item_valid_reg && (!result_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    dsc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .advance(advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Request register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.opcode           <= opcode;
            item_reg.req_length       <= req_length;
            item_reg.service_id       <= service_id;
            item_reg.subfunction_byte <= subfunction_byte;
            item_reg.is_functional    <= is_functional;
            item_reg.elapsed_ms       <= elapsed_ms;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = result_valid_reg;
    assign resp_kind      = result_reg.resp_kind;
    assign resp_sid       = result_reg.resp_sid;
    assign resp_param     = result_reg.resp_param;
    assign nrc_code       = result_reg.nrc_code;
    assign resp_p2        = result_reg.resp_p2;
    assign resp_p2max     = result_reg.resp_p2max;
    assign active_session = result_reg.active_session;
    assign timed_out      = result_reg.timed_out;

endmodule

`default_nettype wire

// File: design/dsc_cfg_regs.sv
// Configuration register file of the diagnostic session controller.
`default_nettype none

module dsc_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [dsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dsc_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    output dsc_pkg::cfg_t                       cfg
);
    import dsc_pkg::*;

    cfg_t cfg_reg;

    // Write the addressed register; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.service_enabled    <= 1'b1;
            cfg_reg.functional_allowed <= 1'b0;
            cfg_reg.p2_time            <= P2_TIME_RESET;
            cfg_reg.p2max_time         <= P2MAX_TIME_RESET;
            cfg_reg.s3_extended_ms     <= S3_RESET;
            cfg_reg.s3_programming_ms  <= S3_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SERVICE_ENABLED:    cfg_reg.service_enabled    <= cfg_wdata[0];
                CFG_FUNCTIONAL_ALLOWED: cfg_reg.functional_allowed <= cfg_wdata[0];
                CFG_P2_TIME:            cfg_reg.p2_time            <= cfg_wdata[TIME_W-1:0];
                CFG_P2MAX_TIME:         cfg_reg.p2max_time         <= cfg_wdata[TIME_W-1:0];
                CFG_S3_EXTENDED:        cfg_reg.s3_extended_ms     <= cfg_wdata[S3_W-1:0];
                CFG_S3_PROGRAMMING:     cfg_reg.s3_programming_ms  <= cfg_wdata[S3_W-1:0];
                default:                ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: design/dsc_core.sv
// Session state, session timer and response decision for one item per cycle while advance is high.
`default_nettype none

module dsc_core (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      advance,
    input  wire dsc_pkg::item_t item,
    input  wire dsc_pkg::cfg_t  cfg,
    output dsc_pkg::result_t result
);
    import dsc_pkg::*;

    session_t          session_reg;
    session_t          session_next;
    logic [S3_W-1:0]   timer_reg;
    logic [S3_W-1:0]   timer_next;
    logic [SEL_W-1:0]  sel;
    logic [S3_W-1:0]   elapsed_ext;
    result_t           res;

    assign sel         = item.subfunction_byte[SEL_W-1:0];
    assign elapsed_ext = {{(S3_W-TIME_W){1'b0}}, item.elapsed_ms};

    // Decide the response and the next session and timer values.
    always_comb
    begin
        res          = '0;
        session_next = session_reg;
        timer_next   = timer_reg;
        case (opcode_t'(item.opcode))
            OP_REQUEST:
            begin
                if (!cfg.service_enabled || (item.is_functional && !cfg.functional_allowed))
                begin
                    res.resp_kind  = RESP_NEGATIVE;
                    res.resp_sid   = SID_NEGATIVE;
                    res.resp_param = item.service_id;
                    res.nrc_code   = NRC_NOT_SUPPORTED;
                end
                else if (item.req_length != VALID_REQ_LEN)
                begin
                    res.resp_kind  = RESP_NEGATIVE;
                    res.resp_sid   = SID_NEGATIVE;
                    res.resp_param = item.service_id;
                    res.nrc_code   = NRC_BAD_LENGTH;
                end
                else if (!(sel inside {SUB_DEFAULT, SUB_PROGRAMMING, SUB_EXTENDED}))
                begin
                    res.resp_kind  = RESP_NEGATIVE;
                    res.resp_sid   = SID_NEGATIVE;
                    res.resp_param = item.service_id;
                    res.nrc_code   = NRC_SUBFUNC_UNSUPPORTED;
                end
                else
                begin
                    session_next = session_t'(sel[1:0]);
                    // The suppress bit silences only the positive response.
                    if (!item.subfunction_byte[BYTE_W-1])
                    begin
                        res.resp_kind  = RESP_POSITIVE;
                        res.resp_sid   = item.service_id | SID_POSITIVE_BIT;
                        res.resp_param = item.subfunction_byte;
                        res.resp_p2    = cfg.p2_time;
                        res.resp_p2max = cfg.p2max_time;
                    end
                end
            end
            OP_RESTART:
            begin
                // The default session has no timeout to load.
                case (session_reg)
                    SESS_EXTENDED:    timer_next = cfg.s3_extended_ms;
                    SESS_PROGRAMMING: timer_next = cfg.s3_programming_ms;
                    default:          ;
                endcase
            end
            OP_TICK:
            begin
                // A stopped timer ignores ticks; expiry falls back to default.
                if (timer_reg != '0)
                begin
                    if (elapsed_ext >= timer_reg)
                    begin
                        timer_next    = '0;
                        session_next  = SESS_DEFAULT;
                        res.timed_out = 1'b1;
                    end
                    else
                    begin
                        timer_next = timer_reg - elapsed_ext;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.active_session = session_next;
    end

    assign result = res;

    // Session state is updated when the item moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg <= SESS_DEFAULT;
            timer_reg   <= '0;
        end
        else if (advance)
        begin
            session_reg <= session_next;
            timer_reg   <= timer_next;
        end
    end

endmodule

`default_nettype wire
